>>> sv/epd_pkg.sv
package epd_pkg;

  // Sequencer states of the servo update.
  typedef enum logic [4:0] {
    S_IDLE,
    S_ERR,
    S_MINC,
    S_ISUM,
    S_MP,
    S_MI,
    S_IQ,
    S_IR,
    S_IA,
    S_IB,
    S_IC,
    S_MK,
    S_MD,
    S_DLD,
    S_DIV,
    S_DADD,
    S_FIN
  } epd_state_e;

  // Register indexes on the configuration port (byte address is 4 times the index).
  localparam logic [2:0] REG_TARGET   = 3'd0;
  localparam logic [2:0] REG_KP       = 3'd1;
  localparam logic [2:0] REG_KI       = 3'd2;
  localparam logic [2:0] REG_KD       = 3'd3;
  localparam logic [2:0] REG_BAND     = 3'd4;
  localparam logic [2:0] REG_ILIMIT   = 3'd5;
  localparam logic [2:0] REG_MINP     = 3'd6;
  localparam logic [2:0] REG_INVERT   = 3'd7;

  // Register reset values.
  localparam logic [31:0] RST_TARGET  = 32'd231;
  localparam logic [15:0] RST_KP      = 16'd512;
  localparam logic [15:0] RST_KI      = 16'd26;
  localparam logic [15:0] RST_KD      = 16'd51;
  localparam logic [7:0]  RST_BAND    = 8'd5;
  localparam logic [15:0] RST_ILIMIT  = 16'd1000;
  localparam logic [9:0]  RST_MINP    = 10'd10;

  // Item commands.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Datapath widths: divider dividend and the control sum accumulator.
  localparam int DIV_W = 58;
  localparam int ACC_W = 60;

  // Position clamp before the error subtraction.
  localparam longint POS_LIMIT = 64'sd8589934592;

  // Milliseconds per second, used for the integral and derivative scaling.
  localparam logic [31:0] MS_PER_S = 32'd1000;

  // Reciprocal of 1000 scaled by 2^36, rounded up; exact for dividends below 2^26.
  localparam logic [31:0] RECIP_1000  = 32'd68719477;
  localparam int          RECIP_SHIFT = 36;

endpackage

>>> sv/encoder_position_pid_drive_top.sv
// Channel   Direction  Transaction                 Fields
// s_axis    in         encoder edge or tick        tuser: cmd; tdata: phase_b, now_ms
// m_axis    out        one result per input item   tdata: drives, position, at_target;
//                                                  tuser: updated
// apb       in         register write or read      eight registers at 4*index
//
// An encoder edge, or a tick that comes before the minimum period, gives its result
// at the accepting edge. A tick inside the stop band gives its result at the next edge,
// once the error step has checked the band. A full update runs ten sequencer steps
// for the error, the integral and the gain products on the shared 32x32 multiplier (the
// scaling by 1000 is a reciprocal multiply), three to set up the derivative, 58 steps of
// the restoring divider for the division by elapsed time, and two to finish.
// With zero elapsed time the derivative steps, the division and its add are skipped.
// The input is not ready while an update runs or while an unaccepted result blocks
// the output register. Reset clears all servo state and loads the register defaults.
module encoder_position_pid_drive_top #(
  parameter int OUTPUT_LIMIT = 255,
  parameter int COUNT_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [0] phase_b, [32:1] now_ms, [39:33] zero.
  input  logic [39:0] s_axis_tdata,
  // tuser: [0] cmd.
  input  logic        s_axis_tuser,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [7:0] drive_forward, [15:8] drive_reverse, [47:16] position,
  // [48] at_target, [55:49] zero.
  output logic [55:0] m_axis_tdata,
  // tuser: [0] updated.
  output logic        m_axis_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import epd_pkg::*;

  localparam int EXT_W = (COUNT_BITS > 35) ? COUNT_BITS + 1 : 36;
  localparam int CNT_W = $clog2(DIV_W);
  localparam logic signed [EXT_W-1:0] PosHi = EXT_W'(POS_LIMIT);
  localparam logic signed [EXT_W-1:0] PosLo = -PosHi;
  localparam logic signed [ACC_W-1:0] UlimS = ACC_W'(OUTPUT_LIMIT * 256);

  // Configuration registers.
  logic signed [31:0] target_q;
  logic [15:0]        kp_q, ki_q, kd_q, ilim_q;
  logic [7:0]         band_q;
  logic [9:0]         minp_q;
  logic               inv_q;

  // Servo state.
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic signed [31:0]    sum_q, sum_d;
  logic signed [31:0]    prev_q, prev_d;
  logic [31:0]           last_q, last_d;
  logic [7:0]            fwd_q, fwd_d, rev_q, rev_d;
  logic                  inband_q, inband_d;

  // Sequencer and working registers.
  epd_state_e          state_q, state_d;
  logic [31:0]         now_q, now_d;
  logic [31:0]         elapsed_q, elapsed_d;
  logic signed [31:0]  err_q, err_d;
  logic [31:0]         dmag_q, dmag_d;
  logic                dneg_q, dneg_d;
  logic [63:0]         prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [31:0]         iq_q, iq_d;
  logic [31:0]         div_r_q, div_r_d;
  logic [DIV_W-1:0]    div_n_q, div_n_d;
  logic [31:0]         div_d_q, div_d_d;
  logic [CNT_W-1:0]    div_cnt_q, div_cnt_d;

  // Output register.
  logic        m_valid_q, m_valid_d;
  logic [48:0] o_data_q, o_data_d;
  logic        o_user_q, o_user_d;

  // Input transaction fields.
  logic        accept;
  logic        in_cmd, in_pb;
  logic [31:0] in_now, elapsed_in;
  logic        held;
  logic [COUNT_BITS-1:0] count_step;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign in_cmd     = s_axis_tuser;
  assign in_pb      = s_axis_tdata[0];
  assign in_now     = s_axis_tdata[32:1];
  assign elapsed_in = in_now - last_q;
  assign held       = elapsed_in < 32'(minp_q);
  assign count_step = (in_pb ^ inv_q) ? count_q + COUNT_BITS'(1) : count_q - COUNT_BITS'(1);

  // Position error, clamped position then saturated to 32 bits.
  logic signed [EXT_W-1:0] count_ext, pos_cl;
  logic signed [35:0]      pos36, diff36;
  logic signed [31:0]      err_c;
  logic [31:0]             err_c_mag;

  always_comb begin
    count_ext = EXT_W'(signed'(count_q));
    if (count_ext > PosHi) begin
      pos_cl = PosHi;
    end else if (count_ext < PosLo) begin
      pos_cl = PosLo;
    end else begin
      pos_cl = count_ext;
    end
    pos36  = $signed(pos_cl[35:0]);
    diff36 = 36'(target_q) - pos36;
    if (diff36 > 36'sd2147483647) begin
      err_c = 32'sh7fffffff;
    end else if (diff36 < -36'sd2147483648) begin
      err_c = 32'sh80000000;
    end else begin
      err_c = $signed(diff36[31:0]);
    end
    err_c_mag = err_c[31] ? 32'(-err_c) : 32'(err_c);
  end

  // Magnitudes of the stored error and integral.
  logic [31:0] err_mag, sum_mag;
  assign err_mag = err_q[31] ? 32'(-err_q) : 32'(err_q);
  assign sum_mag = sum_q[31] ? 32'(-sum_q) : 32'(sum_q);

  // Integral update with step clamp and anti-windup clamp.
  logic [25:0]        lim_mag;
  logic signed [35:0] lim_s, inc_s, sum_new;
  logic [33:0]        inc_mag;
  logic signed [31:0] sum_cl;

  assign lim_mag = {10'd0, ilim_q} * 26'd1000;
  assign lim_s   = $signed({10'd0, lim_mag});

  always_comb begin
    inc_mag = (prod_q > 64'h2_0000_0000) ? 34'h2_0000_0000 : prod_q[33:0];
    inc_s   = err_q[31] ? -$signed({2'b00, inc_mag}) : $signed({2'b00, inc_mag});
    sum_new = 36'(sum_q) + inc_s;
    if (sum_new > lim_s) begin
      sum_cl = 32'(lim_s);
    end else if (sum_new < -lim_s) begin
      sum_cl = 32'(-lim_s);
    end else begin
      sum_cl = 32'(sum_new);
    end
  end

  // Error difference for the derivative term.
  logic signed [32:0] d_s;
  assign d_s = 33'(err_q) - 33'(prev_q);

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // Shared accumulator adder.
  logic [ACC_W-1:0]        add_mag;
  logic                    add_neg;
  logic signed [ACC_W-1:0] add_term, acc_sum;
  assign add_term = add_neg ? -$signed(add_mag) : $signed(add_mag);
  assign acc_sum  = acc_q + add_term;

  // Restoring divider step.
  logic [32:0] div_sh;
  logic        div_ge;
  logic [32:0] div_sub;
  assign div_sh  = {div_r_q, div_n_q[DIV_W-1]};
  assign div_ge  = div_sh >= {1'b0, div_d_q};
  assign div_sub = div_sh - {1'b0, div_d_q};

  // Output clamp and duty.
  logic signed [ACC_W-1:0] u_cl;
  logic [ACC_W-1:0]        u_mag, duty_w;
  logic [7:0]              duty;
  logic                    drive_fwd;

  always_comb begin
    if (acc_q > UlimS) begin
      u_cl = UlimS;
    end else if (acc_q < -UlimS) begin
      u_cl = -UlimS;
    end else begin
      u_cl = acc_q;
    end
    u_mag     = u_cl[ACC_W-1] ? ACC_W'(-u_cl) : ACC_W'(u_cl);
    duty_w    = u_mag >> 8;
    duty      = (duty_w > ACC_W'(255)) ? 8'hff : duty_w[7:0];
    drive_fwd = (acc_q > 0) != inv_q;
  end

  // Next state and datapath control.
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    sum_d      = sum_q;
    prev_d     = prev_q;
    last_d     = last_q;
    fwd_d      = fwd_q;
    rev_d      = rev_q;
    inband_d   = inband_q;
    now_d      = now_q;
    elapsed_d  = elapsed_q;
    err_d      = err_q;
    dmag_d     = dmag_q;
    dneg_d     = dneg_q;
    prod_d     = prod_q;
    acc_d      = acc_q;
    iq_d       = iq_q;
    div_r_d    = div_r_q;
    div_n_d    = div_n_q;
    div_d_d    = div_d_q;
    div_cnt_d  = div_cnt_q;
    o_data_d   = o_data_q;
    o_user_d   = o_user_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    mul_a      = err_mag;
    mul_b      = elapsed_q;
    add_mag    = prod_q[ACC_W-1:0];
    add_neg    = err_q[31];

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_EDGE) begin
            count_d   = count_step;
            o_data_d  = {inband_q, 32'(count_step), rev_q, fwd_q};
            o_user_d  = 1'b0;
            m_valid_d = 1'b1;
          end else if (held) begin
            o_data_d  = {inband_q, 32'(count_q), rev_q, fwd_q};
            o_user_d  = 1'b0;
            m_valid_d = 1'b1;
          end else begin
            now_d     = in_now;
            elapsed_d = elapsed_in;
            state_d   = S_ERR;
          end
        end
      end
      S_ERR: begin
        err_d = err_c;
        if (err_c_mag < 32'(band_q)) begin
          fwd_d     = 8'd0;
          rev_d     = 8'd0;
          inband_d  = 1'b1;
          o_data_d  = {1'b1, 32'(count_q), 8'd0, 8'd0};
          o_user_d  = 1'b0;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end else begin
          state_d = S_MINC;
        end
      end
      S_MINC: begin
        // Integral increment magnitude: |error| times elapsed.
        prod_d  = mul_p;
        state_d = S_ISUM;
      end
      S_ISUM: begin
        sum_d   = sum_cl;
        acc_d   = '0;
        state_d = S_MP;
      end
      S_MP: begin
        mul_b   = 32'(kp_q);
        prod_d  = mul_p;
        state_d = S_MI;
      end
      S_MI: begin
        // Add the proportional term, start splitting the integral into thousands.
        acc_d   = acc_sum;
        mul_a   = sum_mag;
        mul_b   = RECIP_1000;
        prod_d  = mul_p;
        state_d = S_IQ;
      end
      S_IQ: begin
        // Whole thousands of the integral magnitude, and their product with 1000.
        iq_d    = 32'(prod_q[63:RECIP_SHIFT]);
        mul_a   = 32'(prod_q[63:RECIP_SHIFT]);
        mul_b   = MS_PER_S;
        prod_d  = mul_p;
        state_d = S_IR;
      end
      S_IR: begin
        // Remainder below a thousand, times the integral gain.
        mul_a   = sum_mag - prod_q[31:0];
        mul_b   = 32'(ki_q);
        prod_d  = mul_p;
        state_d = S_IA;
      end
      S_IA: begin
        // Keep the remainder product, then the gain times the whole thousands.
        iq_d    = prod_q[31:0];
        mul_a   = iq_q;
        mul_b   = 32'(ki_q);
        prod_d  = mul_p;
        state_d = S_IB;
      end
      S_IB: begin
        // Add the whole-thousands part, then divide the remainder product by 1000.
        add_neg = sum_q[31];
        acc_d   = acc_sum;
        mul_a   = iq_q;
        mul_b   = RECIP_1000;
        prod_d  = mul_p;
        state_d = S_IC;
      end
      S_IC: begin
        add_mag = ACC_W'(prod_q[63:RECIP_SHIFT]);
        add_neg = sum_q[31];
        acc_d   = acc_sum;
        if (elapsed_q == 32'd0) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MK;
        end
      end
      S_MK: begin
        // Derivative gain scaled to milliseconds, and the error difference.
        mul_a   = MS_PER_S;
        mul_b   = 32'(kd_q);
        prod_d  = mul_p;
        dmag_d  = d_s[32] ? 32'(-d_s) : 32'(d_s);
        dneg_d  = d_s[32];
        state_d = S_MD;
      end
      S_MD: begin
        mul_a   = dmag_q;
        mul_b   = prod_q[31:0];
        prod_d  = mul_p;
        state_d = S_DLD;
      end
      S_DLD: begin
        div_n_d   = prod_q[DIV_W-1:0];
        div_r_d   = '0;
        div_d_d   = elapsed_q;
        div_cnt_d = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        div_r_d   = div_ge ? div_sub[31:0] : div_sh[31:0];
        div_n_d   = {div_n_q[DIV_W-2:0], div_ge};
        div_cnt_d = div_cnt_q + CNT_W'(1);
        if (div_cnt_q == CNT_W'(DIV_W - 1)) begin
          state_d = S_DADD;
        end
      end
      S_DADD: begin
        add_mag = ACC_W'(div_n_q);
        add_neg = dneg_q;
        acc_d   = acc_sum;
        state_d = S_FIN;
      end
      S_FIN: begin
        fwd_d     = drive_fwd ? duty : 8'd0;
        rev_d     = drive_fwd ? 8'd0 : duty;
        prev_d    = err_q;
        last_d    = now_q;
        inband_d  = 1'b0;
        o_data_d  = {1'b0, 32'(count_q), drive_fwd ? 8'd0 : duty, drive_fwd ? duty : 8'd0};
        o_user_d  = 1'b1;
        m_valid_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control and servo state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      sum_q     <= '0;
      prev_q    <= '0;
      last_q    <= '0;
      fwd_q     <= '0;
      rev_q     <= '0;
      inband_q  <= 1'b0;
      m_valid_q <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      prev_q    <= prev_d;
      last_q    <= last_d;
      fwd_q     <= fwd_d;
      rev_q     <= rev_d;
      inband_q  <= inband_d;
      m_valid_q <= m_valid_d;
      div_cnt_q <= div_cnt_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    elapsed_q <= elapsed_d;
    err_q     <= err_d;
    dmag_q    <= dmag_d;
    dneg_q    <= dneg_d;
    prod_q    <= prod_d;
    acc_q     <= acc_d;
    iq_q      <= iq_d;
    div_r_q   <= div_r_d;
    div_n_q   <= div_n_d;
    div_d_q   <= div_d_d;
    o_data_q  <= o_data_d;
    o_user_q  <= o_user_d;
  end

  // Configuration writes.
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= signed'(RST_TARGET);
      kp_q     <= RST_KP;
      ki_q     <= RST_KI;
      kd_q     <= RST_KD;
      band_q   <= RST_BAND;
      ilim_q   <= RST_ILIMIT;
      minp_q   <= RST_MINP;
      inv_q    <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_TARGET: target_q <= signed'(pwdata);
        REG_KP:     kp_q     <= pwdata[15:0];
        REG_KI:     ki_q     <= pwdata[15:0];
        REG_KD:     kd_q     <= pwdata[15:0];
        REG_BAND:   band_q   <= pwdata[7:0];
        REG_ILIMIT: ilim_q   <= pwdata[15:0];
        REG_MINP:   minp_q   <= pwdata[9:0];
        REG_INVERT: inv_q    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[4:2])
      REG_TARGET: prdata = 32'(target_q);
      REG_KP:     prdata = 32'(kp_q);
      REG_KI:     prdata = 32'(ki_q);
      REG_KD:     prdata = 32'(kd_q);
      REG_BAND:   prdata = 32'(band_q);
      REG_ILIMIT: prdata = 32'(ilim_q);
      REG_MINP:   prdata = 32'(minp_q);
      REG_INVERT: prdata = 32'(inv_q);
      default:    prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE) && (!m_valid_q || m_axis_tready);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, o_data_q};
  assign m_axis_tuser  = o_user_q;

  // The output register must be free when an update finishes.
  a_fin_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> !m_valid_q)
    else $error("update finished while a result was still pending");

  // Only one drive pin is ever active.
  a_one_pin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwd_q == 8'd0) || (rev_q == 8'd0))
    else $error("both drive pins active");

  // An update result never reports the stop band.
  a_update_not_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && o_user_q) |-> !o_data_q[48])
    else $error("update result flagged inside stop band");

  // The divider finishes its pass and hands over to the accumulate step.
  a_div_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_cnt_q == CNT_W'(DIV_W - 1)) |=> (state_q == S_DADD))
    else $error("divider pass did not end in the accumulate step");

endmodule
